FILE: src/bm25_pkg.sv
// bm25_pkg: shared constants, widths and register indexes for the BM25 scorer.
// No dependencies; used by the channel interfaces and bm25_document_score_top.
`default_nettype none

package bm25_pkg;

  // Fraction bits of term_score and doc_score.
  localparam int unsigned FRAC_BITS   = 16;
  // Shift that takes |idf| (Q.28) times tfc (Q.24) down to FRAC_BITS.
  localparam int unsigned SCORE_SHIFT = 52 - FRAC_BITS;

  // ln(2) with 28 fraction bits.
  localparam logic [27:0] LN2_Q28 = 28'd186065279;

  localparam int unsigned TF_W    = 16;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned DF_W    = 24;
  localparam int unsigned TERM_W  = 32;
  localparam int unsigned SUM_W   = 48;

  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 32;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_K1_FACTOR   = 2'd0,
    REG_LENGTH_NORM = 2'd1,
    REG_N_DOCS      = 2'd2,
    REG_AVG_LEN     = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] K1_RESET  = 16'd4915;
  localparam logic [12:0] B_RESET   = 13'd3072;
  localparam logic [12:0] B_ONE     = 13'd4096;
  localparam logic [31:0] AVG_MIN   = 32'd65536;

endpackage

`default_nettype wire

FILE: src/bm25_if.sv
// bm25_in_if / bm25_out_if: valid-ready channels for term items and score items.
// Depends on bm25_pkg for field widths.
`default_nettype none

interface bm25_in_if import bm25_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TF_W-1:0]   term_freq;
  logic [LEN_W-1:0]  doc_len;
  logic [DF_W-1:0]   doc_freq;
  logic              last_term;

  modport source (output valid, term_freq, doc_len, doc_freq, last_term, input ready);
  modport sink   (input valid, term_freq, doc_len, doc_freq, last_term, output ready);
endinterface

interface bm25_out_if import bm25_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TERM_W-1:0] term_score;
  logic signed [SUM_W-1:0]  doc_score;
  logic                     score_done;

  modport source (output valid, term_score, doc_score, score_done, input ready);
  modport sink   (input valid, term_score, doc_score, score_done, output ready);
endinterface

`default_nettype wire

FILE: src/bm25_document_score_top.sv
// bm25_document_score_top: Okapi BM25 term scorer with per-document accumulator.
// Depends on bm25_pkg and the channel interfaces in bm25_if.sv.
//
// Usage:
//   in_ch  carries one query term per item: term_freq, doc_len, doc_freq and
//          last_term. in_ch.ready is high only while the sequencer is idle.
//   out_ch returns one item per input item: the term score, the running document
//          score including that term, and score_done (copy of last_term). After
//          an item marked last the running sum is cleared.
//   cfg_*  APB-style register port: k1_factor @0x0, length_norm @0x4,
//          document count N @0x8, mean document length @0xC. Write only while idle.
// Processing:
//   An item with zero frequency goes from accept straight to the output step,
//   which loads the output register. Any other item passes through two
//   logarithms (squaring unit, one fraction bit per cycle), a 40-step and a
//   32-step restoring division sharing one subtract/compare unit, plus five
//   setup, multiply and output steps. The squarer and the shared divider take
//   up most of the work. A new item is taken only once the previous one has
//   reached the output register.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   running sum clears, no result is pending.
// Stall: a finished result is held in the output register until taken; the
//   next item may be accepted meanwhile, and its result waits in the last
//   step until the output register frees.
`default_nettype none

module bm25_document_score_top import bm25_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bm25_in_if.sink                in_ch,
  bm25_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOGN, S_LOGS, S_IDF, S_DIV1, S_NORM, S_KN, S_DIV2, S_MAG, S_OUT
  } state_t;

  // Control
  state_t st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic sel_c_r, sel_c_nxt;

  // Configuration
  logic [15:0] k1_r;
  logic [12:0] b_r;
  logic [23:0] n_r;
  logic [31:0] avg_r;

  // Item payload
  logic [TF_W-1:0]  tf_r, tf_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [DF_W-1:0]  df_r, df_nxt;
  logic             last_r, last_nxt;

  // Datapath
  logic [32:0] la_r, la_nxt;
  logic [30:0] m_r, m_nxt;
  logic [32:0] r_r, r_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] idfm_r, idfm_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [46:0] dvs_r, dvs_nxt;
  logic [39:0] quo_r, quo_nxt;
  logic [41:0] norm_r, norm_nxt;
  logic [32:0] numer_r, numer_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Output register
  logic                     ov_r, ov_nxt;
  logic signed [TERM_W-1:0] o_term_r, o_term_nxt;
  logic signed [SUM_W-1:0]  o_sum_r, o_sum_nxt;
  logic                     o_done_r, o_done_nxt;

  // Combinational helpers
  logic        in_acc, out_acc, cfg_wr;
  logic [24:0] log_x;
  logic [4:0]  log_e;
  logic [61:0] sq_p;
  logic [31:0] sq_q;
  logic [32:0] diff;
  logic [60:0] idf_p;
  logic        dbit;
  logic [47:0] div_t;
  logic        div_ge;
  logic [12:0] b_sat;
  logic [31:0] avg_sat;
  logic [52:0] bn_p;
  logic [53:0] norm_s;
  logic [57:0] kn_p;
  logic [65:0] mag_p;
  logic [65:0] mag;
  logic signed [SUM_W:0] sum_w;
  logic [1:0]  cfg_idx;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = ov_r && out_ch.ready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  assign in_ch.ready       = (st_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.term_score = o_term_r;
  assign out_ch.doc_score  = o_sum_r;
  assign out_ch.score_done = o_done_r;
  assign cfg_pready        = 1'b1;

  always_comb begin
    case (cfg_reg_t'(cfg_idx))
      REG_K1_FACTOR:   cfg_prdata = {16'd0, k1_r};
      REG_LENGTH_NORM: cfg_prdata = {19'd0, b_r};
      REG_N_DOCS:      cfg_prdata = {8'd0, n_r};
      REG_AVG_LEN:     cfg_prdata = avg_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // Log operand: 2(N-df)+1 first, then 2df+1.
  always_comb begin
    log_x = sel_c_r ? {df_r, 1'b1} : {n_r - df_r, 1'b1};
    log_e = '0;
    for (int i = 0; i < 25; i++) begin
      if (log_x[i]) log_e = 5'(i);
    end
  end

  assign sq_p = 62'(m_r) * 62'(m_r);
  assign sq_q = sq_p[61:30];

  assign diff  = (la_r < r_r) ? (r_r - la_r) : (la_r - r_r);
  assign idf_p = 61'(diff) * 61'(LN2_Q28) + (61'd1 << 27);

  // Shared restoring divider: bring in one dividend bit per step.
  always_comb begin
    if (st_r == S_DIV1) dbit = (cnt_r >= 6'd32) ? len_r[cnt_r[2:0]] : 1'b0;
    else                dbit = (cnt_r >= 6'd28) ? numer_r[cnt_r[1:0]] : 1'b0;
  end
  assign div_t  = {rem_r[46:0], dbit};
  assign div_ge = div_t >= {1'b0, dvs_r};

  assign b_sat   = (b_r > B_ONE) ? B_ONE : b_r;
  assign avg_sat = (avg_r < AVG_MIN) ? AVG_MIN : avg_r;
  assign bn_p    = 53'(b_sat) * 53'(quo_r);
  assign norm_s  = (54'(B_ONE - b_sat) << 16) + 54'(bn_p);
  assign kn_p    = 58'(k1_r) * 58'(norm_r);
  assign mag_p   = 66'(idfm_r) * 66'(quo_r[31:0]) + (66'd1 << (SCORE_SHIFT - 1));
  assign mag     = mag_p >> SCORE_SHIFT;
  assign sum_w   = {sum_r[SUM_W-1], sum_r} + (SUM_W+1)'(signed'(term_r));

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    sel_c_nxt  = sel_c_r;
    tf_nxt     = tf_r;
    len_nxt    = len_r;
    df_nxt     = df_r;
    last_nxt   = last_r;
    la_nxt     = la_r;
    m_nxt      = m_r;
    r_nxt      = r_r;
    neg_nxt    = neg_r;
    idfm_nxt   = idfm_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    quo_nxt    = quo_r;
    norm_nxt   = norm_r;
    numer_nxt  = numer_r;
    term_nxt   = term_r;
    sum_nxt    = sum_r;
    ov_nxt     = out_acc ? 1'b0 : ov_r;
    o_term_nxt = o_term_r;
    o_sum_nxt  = o_sum_r;
    o_done_nxt = o_done_r;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          tf_nxt    = in_ch.term_freq;
          len_nxt   = in_ch.doc_len;
          // Saturate df to N.
          df_nxt    = (in_ch.doc_freq > n_r) ? n_r : in_ch.doc_freq;
          last_nxt  = in_ch.last_term;
          sel_c_nxt = 1'b0;
          term_nxt  = '0;
          st_nxt    = (in_ch.term_freq == '0) ? S_OUT : S_LOGN;
        end
      end
      S_LOGN: begin
        m_nxt   = 31'(log_x) << (5'd30 - log_e);
        r_nxt   = {log_e, 28'd0};
        cnt_nxt = 6'd27;
        st_nxt  = S_LOGS;
      end
      S_LOGS: begin
        if (sq_q[31]) begin
          m_nxt = sq_q[31:1];
          r_nxt = r_r | (33'd1 << cnt_r[4:0]);
        end else begin
          m_nxt = sq_q[30:0];
        end
        if (cnt_r == '0) begin
          if (!sel_c_r) begin
            la_nxt    = r_nxt;
            sel_c_nxt = 1'b1;
            st_nxt    = S_LOGN;
          end else begin
            st_nxt = S_IDF;
          end
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_IDF: begin
        // r_r now holds log2 of 2df+1.
        neg_nxt  = la_r < r_r;
        idfm_nxt = idf_p[60:28];
        rem_nxt  = 48'(len_r >> 8);
        dvs_nxt  = 47'(avg_sat);
        cnt_nxt  = 6'd39;
        st_nxt   = S_DIV1;
      end
      S_DIV1, S_DIV2: begin
        rem_nxt = div_ge ? (div_t - {1'b0, dvs_r}) : div_t;
        quo_nxt = {quo_r[38:0], div_ge};
        if (cnt_r == '0) st_nxt = (st_r == S_DIV1) ? S_NORM : S_MAG;
        else             cnt_nxt = cnt_r - 6'd1;
      end
      S_NORM: begin
        norm_nxt = norm_s[53:12];
        st_nxt   = S_KN;
      end
      S_KN: begin
        numer_nxt = 33'(tf_r) * 33'(17'(k1_r) + 17'(B_ONE));
        dvs_nxt   = 47'({tf_r, 16'd0}) + 47'(kn_p[57:12]);
        rem_nxt   = 48'(numer_nxt >> 4);
        cnt_nxt   = 6'd31;
        st_nxt    = S_DIV2;
      end
      S_MAG: begin
        if (neg_r) begin
          term_nxt = (mag > 66'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
        end else begin
          term_nxt = (mag > 66'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_term_nxt = signed'(term_r);
          if (sum_w > (SUM_W+1)'(signed'({1'b0, {(SUM_W-1){1'b1}}})))
            o_sum_nxt = {1'b0, {(SUM_W-1){1'b1}}};
          else if (sum_w < (SUM_W+1)'(signed'({1'b1, {(SUM_W-1){1'b0}}})))
            o_sum_nxt = {1'b1, {(SUM_W-1){1'b0}}};
          else
            o_sum_nxt = sum_w[SUM_W-1:0];
          o_done_nxt = last_r;
          sum_nxt    = last_r ? '0 : o_sum_nxt;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      cnt_r   <= '0;
      sel_c_r <= 1'b0;
      sum_r   <= '0;
      ov_r    <= 1'b0;
      k1_r    <= K1_RESET;
      b_r     <= B_RESET;
      n_r     <= '0;
      avg_r   <= AVG_MIN;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      sel_c_r <= sel_c_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr) begin
        case (cfg_reg_t'(cfg_idx))
          REG_K1_FACTOR:   k1_r  <= cfg_pwdata[15:0];
          REG_LENGTH_NORM: b_r   <= cfg_pwdata[12:0];
          REG_N_DOCS:      n_r   <= cfg_pwdata[23:0];
          REG_AVG_LEN:     avg_r <= cfg_pwdata;
          default: ;
        endcase
      end
    end
    tf_r     <= tf_nxt;
    len_r    <= len_nxt;
    df_r     <= df_nxt;
    last_r   <= last_nxt;
    la_r     <= la_nxt;
    m_r      <= m_nxt;
    r_r      <= r_nxt;
    neg_r    <= neg_nxt;
    idfm_r   <= idfm_nxt;
    rem_r    <= rem_nxt;
    dvs_r    <= dvs_nxt;
    quo_r    <= quo_nxt;
    norm_r   <= norm_nxt;
    numer_r  <= numer_nxt;
    term_r   <= term_nxt;
    o_term_r <= o_term_nxt;
    o_sum_r  <= o_sum_nxt;
    o_done_r <= o_done_nxt;
  end

  // Busy after accept: one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready) else $error("accepted item while busy");

  // Sum is cleared whenever a final score sits in the output register.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && o_done_r |-> sum_r == '0) else $error("sum not cleared after last");

  // Partial remainder stays below the divisor.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV1 || st_r == S_DIV2) |-> rem_r < {1'b0, dvs_r})
    else $error("divider remainder out of range");

endmodule

`default_nettype wire
